// File: src/ack_timeout_retry_tracker_assert.svh
// Assertion macros shared by the tracker modules.
`ifndef ACK_TIMEOUT_RETRY_TRACKER_ASSERT_SVH
`define ACK_TIMEOUT_RETRY_TRACKER_ASSERT_SVH

// An implication that must hold at every clock edge outside reset.
`define ATRT_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// An implication checked in the cycle after the condition.
`define ATRT_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

// File: src/atrt_pkg.sv
package atrt_pkg;

  localparam logic [2:0] CMD_TRACK      = 3'd0;
  localparam logic [2:0] CMD_ACK        = 3'd1;
  localparam logic [2:0] CMD_NACK       = 3'd2;
  localparam logic [2:0] CMD_DISCONNECT = 3'd3;
  localparam logic [2:0] CMD_TICK       = 3'd4;

  localparam logic [2:0] ACT_DONE      = 3'd0;
  localparam logic [2:0] ACT_REQUEUED  = 3'd1;
  localparam logic [2:0] ACT_DEAD      = 3'd2;
  localparam logic [2:0] ACT_NOT_FOUND = 3'd3;
  localparam logic [2:0] ACT_FULL      = 3'd4;

  localparam logic [19:0] WINDOW_RESET = 20'd5000;
  localparam logic [7:0]  LIMIT_RESET  = 8'd3;

  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] msg_id;
    logic [15:0] client_id;
    logic [31:0] now_ms;
  } atrt_item_t;

endpackage

// File: src/ack_timeout_retry_tracker.sv
// Command tracker for in-flight messages. Each command waits in a two-entry queue, so start is
// taken while the back end works and busy rises only when the queue is full. The back end takes
// a command from the queue, scans the table slots (NUM_ENTRIES) one per cycle and then closes
// the command; an unknown command skips the scan. Results appear on done for one cycle each and
// cannot be stalled. During a disconnect or tick scan each result is held until the next match or
// the closing cycle, so that last marks the final result of a command.
module ack_timeout_retry_tracker #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [63:0] msg_id,
  input  logic [15:0] client_id,
  input  logic [31:0] now_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output logic        done,
  output logic [2:0]  action,
  output logic [63:0] out_msg_id,
  output logic [15:0] out_client_id,
  output logic [7:0]  out_retries,
  output logic        last
);
  import atrt_pkg::*;

  atrt_item_t in_item;
  atrt_item_t q_item;
  logic       q_valid;
  logic       q_pop;
  logic [19:0] ack_window;
  logic [7:0]  retry_limit;

  assign in_item   = '{command: command, msg_id: msg_id, client_id: client_id, now_ms: now_ms};
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_window  <= WINDOW_RESET;
      retry_limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index[0] == CFG_WINDOW) begin
        ack_window <= cfg_data;
      end else begin
        retry_limit <= cfg_data[7:0];
      end
    end
  end

  atrt_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  atrt_back #(.NUM_ENTRIES(NUM_ENTRIES)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .ack_window(ack_window), .retry_limit(retry_limit), .done(done),
    .action(action), .out_msg_id(out_msg_id), .out_client_id(out_client_id),
    .out_retries(out_retries), .last(last)
  );
endmodule

// File: src/atrt_front.sv
module atrt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  atrt_pkg::atrt_item_t in_item,
  output logic                q_valid,
  output atrt_pkg::atrt_item_t q_item,
  input  logic                q_pop
);
  import atrt_pkg::*;

  atrt_item_t buf_item [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_item  = buf_item[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_item[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

`include "ack_timeout_retry_tracker_assert.svh"
  `ATRT_ASSERT_IMP(a_no_pop_empty, clk, rst, q_pop, q_valid)
  `ATRT_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= 2'd2)
  `ATRT_ASSERT_NEXT(a_push_fills, clk, rst, push && !q_pop, count != 2'd0)
endmodule

// File: src/atrt_back.sv
module atrt_back #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  atrt_pkg::atrt_item_t q_item,
  output logic                 q_pop,
  input  logic [19:0]          ack_window,
  input  logic [7:0]           retry_limit,
  output logic                 done,
  output logic [2:0]           action,
  output logic [63:0]          out_msg_id,
  output logic [15:0]          out_client_id,
  output logic [7:0]           out_retries,
  output logic                 last
);
  import atrt_pkg::*;

  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t      state;
  atrt_item_t  cur;
  logic [IW-1:0] idx;
  logic        found;
  logic [IW-1:0] found_idx;
  logic        have_free;
  logic [IW-1:0] free_idx;
  logic        any_hit;

  logic [NUM_ENTRIES-1:0] slot_valid;
  logic [63:0] slot_msg_id   [NUM_ENTRIES];
  logic [15:0] slot_client   [NUM_ENTRIES];
  logic [31:0] slot_deadline [NUM_ENTRIES];
  logic [7:0]  slot_retries  [NUM_ENTRIES];

  logic        s_valid;
  logic [63:0] s_id;
  logic [15:0] s_client;
  logic [31:0] s_deadline;
  logic [7:0]  s_retries;
  logic [7:0]  s_bumped;
  logic [31:0] new_deadline;
  logic [31:0] age;
  logic        id_hit;
  logic        scan_hit;
  logic        is_last;
  logic        is_scan_cmd;

  logic [2:0]  p_action;
  logic [63:0] p_id;
  logic [15:0] p_client;
  logic [7:0]  p_retries;

  assign s_valid      = slot_valid[idx];
  assign s_id         = slot_msg_id[idx];
  assign s_client     = slot_client[idx];
  assign s_deadline   = slot_deadline[idx];
  assign s_retries    = slot_retries[idx];
  assign s_bumped     = (s_retries == 8'hFF) ? s_retries : s_retries + 8'd1;
  assign new_deadline = cur.now_ms + {12'd0, ack_window};
  assign age          = cur.now_ms - s_deadline;
  assign id_hit       = s_valid && (s_id == cur.msg_id);
  assign is_last      = (idx == LAST_IDX);
  assign is_scan_cmd  = (cur.command == CMD_DISCONNECT) || (cur.command == CMD_TICK);
  assign scan_hit     = s_valid && ((cur.command == CMD_DISCONNECT) ?
                        (s_client == cur.client_id) : !age[31]);
  assign q_pop        = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur       <= q_item;
            idx       <= '0;
            found     <= 1'b0;
            have_free <= 1'b0;
            any_hit   <= 1'b0;
            state     <= (q_item.command <= CMD_TICK) ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          if (is_scan_cmd) begin
            if (scan_hit) begin
              any_hit  <= 1'b1;
              p_id     <= s_id;
              p_client <= s_client;
              if (s_retries >= retry_limit) begin
                slot_valid[idx] <= 1'b0;
                p_action        <= ACT_DEAD;
                p_retries       <= s_retries;
              end else begin
                slot_retries[idx]  <= s_bumped;
                slot_deadline[idx] <= new_deadline;
                p_action           <= ACT_REQUEUED;
                p_retries          <= s_bumped;
              end
              if (any_hit) begin
                done          <= 1'b1;
                last          <= 1'b0;
                action        <= p_action;
                out_msg_id    <= p_id;
                out_client_id <= p_client;
                out_retries   <= p_retries;
              end
            end
          end else begin
            if (id_hit && !found) begin
              found     <= 1'b1;
              found_idx <= idx;
            end
            if (!s_valid && !have_free) begin
              have_free <= 1'b1;
              free_idx  <= idx;
            end
          end
          if (is_last) begin
            state <= S_DONE;
          end
          idx <= idx + IW'(1);
        end
        S_DONE: begin
          done          <= 1'b1;
          last          <= 1'b1;
          out_msg_id    <= cur.msg_id;
          out_client_id <= 16'd0;
          out_retries   <= 8'd0;
          action        <= ACT_NOT_FOUND;
          state         <= S_IDLE;
          if (cur.command > CMD_TICK) begin
            out_msg_id <= 64'd0;
          end else if (is_scan_cmd && any_hit) begin
            action        <= p_action;
            out_msg_id    <= p_id;
            out_client_id <= p_client;
            out_retries   <= p_retries;
          end else if (cur.command == CMD_DISCONNECT) begin
            out_msg_id    <= 64'd0;
            out_client_id <= cur.client_id;
          end else if (cur.command == CMD_TICK) begin
            action     <= ACT_DONE;
            out_msg_id <= 64'd0;
          end else if (cur.command == CMD_TRACK) begin
            if (found) begin
              slot_client[found_idx]   <= cur.client_id;
              slot_deadline[found_idx] <= new_deadline;
              action        <= ACT_DONE;
              out_client_id <= cur.client_id;
              out_retries   <= slot_retries[found_idx];
            end else if (have_free) begin
              slot_valid[free_idx]    <= 1'b1;
              slot_msg_id[free_idx]   <= cur.msg_id;
              slot_retries[free_idx]  <= 8'd0;
              slot_client[free_idx]   <= cur.client_id;
              slot_deadline[free_idx] <= new_deadline;
              action        <= ACT_DONE;
              out_client_id <= cur.client_id;
            end else begin
              action        <= ACT_FULL;
              out_client_id <= cur.client_id;
            end
          end else if (found) begin
            out_client_id <= slot_client[found_idx];
            out_retries   <= slot_retries[found_idx];
            if (cur.command == CMD_ACK) begin
              slot_valid[found_idx] <= 1'b0;
              action <= ACT_DONE;
            end else if (slot_retries[found_idx] >= retry_limit) begin
              slot_valid[found_idx] <= 1'b0;
              action <= ACT_DEAD;
            end else begin
              slot_deadline[found_idx] <= new_deadline;
              action <= ACT_REQUEUED;
              if (slot_retries[found_idx] != 8'hFF) begin
                slot_retries[found_idx] <= slot_retries[found_idx] + 8'd1;
                out_retries <= slot_retries[found_idx] + 8'd1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "ack_timeout_retry_tracker_assert.svh"
  `ATRT_ASSERT_IMP(a_pop_idle, clk, rst, q_pop, state == S_IDLE)
  `ATRT_ASSERT_IMP(a_onehot, clk, rst, 1'b1, $onehot(state))
  `ATRT_ASSERT_NEXT(a_last_idle, clk, rst, state == S_DONE, state == S_IDLE)
endmodule
